@@ rtl/wcbc_pkg.sv @@
`timescale 1ns / 1ps
package wcbc_pkg;

  localparam int MAX_DIM_DEF   = 4096;
  localparam int AREA_BITS_DEF = 40;

  localparam int CRD_W      = 15;   // box edge sums and capped image sizes
  localparam int RA_W       = 17;
  localparam int CNT_W      = 16;
  localparam int OUT_AREA_W = 40;
  localparam int RATIO_W    = 24;
  localparam int FRAC_W     = 16;
  localparam int QDEPTH     = 2;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [RA_W-1:0]  ONE_Q16 = 17'h10000;
  localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

  localparam logic [1:0] CMD_BEGIN = 2'd0;
  localparam logic [1:0] CMD_BOX   = 2'd1;
  localparam logic [1:0] CMD_END   = 2'd2;

  localparam logic [1:0] REG_ROOT_ALPHA  = 2'd0;
  localparam logic [1:0] REG_AREA_THR    = 2'd1;
  localparam logic [1:0] REG_COUNT_THR   = 2'd2;

  localparam logic [RA_W-1:0]  ROOT_ALPHA_RST = 17'd65536;
  localparam logic [RA_W-1:0]  AREA_THR_RST   = 17'd32768;
  localparam logic [CNT_W-1:0] COUNT_THR_RST  = 16'd10;

  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_BOX   = 2'd1,
    OP_END   = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [11:0] box_left;
    logic [11:0] box_top;
    logic [12:0] box_width;
    logic [12:0] box_height;
  } in_item_t;

  typedef struct packed {
    logic                  full_screen;
    logic [CNT_W-1:0]      boxes_inside;
    logic [OUT_AREA_W-1:0] covered_area;
    logic [RATIO_W-1:0]    area_ratio;
  } out_item_t;

  typedef struct packed {
    logic [RA_W-1:0]  root_alpha;
    logic [RA_W-1:0]  area_threshold;
    logic [CNT_W-1:0] count_threshold;
  } cfg_t;

  // begin: x1/y1 carry the capped image size; box: x0,y0 .. x1,y1 edges
  typedef struct packed {
    op_t              op;
    logic [CRD_W-1:0] x0;
    logic [CRD_W-1:0] y0;
    logic [CRD_W-1:0] x1;
    logic [CRD_W-1:0] y1;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

endpackage

@@ rtl/wcbc_front.sv @@
`timescale 1ns / 1ps
module wcbc_front import wcbc_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic     in_valid,
  input  in_item_t in_item,
  output logic     in_stall,
  input  q_stat_t  q_stat,
  output logic     push,
  output q_entry_t ent
);

  logic             acc;
  logic [CRD_W-1:0] w_cap;
  logic [CRD_W-1:0] h_cap;

  assign in_stall = q_stat.full;
  assign acc      = in_valid && !q_stat.full;

  assign w_cap = ({2'b00, in_item.image_width} > CRD_W'(MAX_DIM)) ?
                 CRD_W'(MAX_DIM) : CRD_W'(in_item.image_width);
  assign h_cap = ({2'b00, in_item.image_height} > CRD_W'(MAX_DIM)) ?
                 CRD_W'(MAX_DIM) : CRD_W'(in_item.image_height);

  always_comb begin
    push   = 1'b0;
    ent.op = OP_END;
    ent.x0 = '0;
    ent.y0 = '0;
    ent.x1 = '0;
    ent.y1 = '0;
    case (in_item.command)
      CMD_BEGIN: begin
        push   = acc;
        ent.op = OP_BEGIN;
        ent.x1 = w_cap;
        ent.y1 = h_cap;
      end
      CMD_BOX: begin
        push   = acc;
        ent.op = OP_BOX;
        ent.x0 = CRD_W'(in_item.box_left);
        ent.y0 = CRD_W'(in_item.box_top);
        ent.x1 = CRD_W'(in_item.box_left) + CRD_W'(in_item.box_width);
        ent.y1 = CRD_W'(in_item.box_top) + CRD_W'(in_item.box_height);
      end
      CMD_END: begin
        push   = acc;
        ent.op = OP_END;
      end
      default: begin
        push = 1'b0;  // unused command: taken and dropped
      end
    endcase
  end

endmodule

@@ rtl/wcbc_queue.sv @@
`timescale 1ns / 1ps
module wcbc_queue import wcbc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t ent_in,
  input  logic     pop,
  output q_entry_t head,
  output q_stat_t  q_stat
);

  localparam int PTR_W = $clog2(QDEPTH);

  q_entry_t         mem_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W:0]   cnt_r;

  assign head             = mem_r[rd_ptr_r];
  assign q_stat.full      = (cnt_r == (PTR_W+1)'(QDEPTH));
  assign q_stat.not_empty = (cnt_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= ent_in;
    end
  end

endmodule

@@ rtl/wcbc_div.sv @@
`timescale 1ns / 1ps
module wcbc_div import wcbc_pkg::*; #(
  parameter int AREA_BITS = AREA_BITS_DEF,
  parameter int DEN_W     = 25
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [AREA_BITS-1:0] num,
  input  logic [DEN_W-1:0]     den,
  output logic                 busy,
  output logic [RATIO_W-1:0]   quot
);

  // quotient of (num << FRAC_W) / den, one bit per cycle
  localparam int PRE_W  = RATIO_W - FRAC_W;
  localparam int CMP_W  = (AREA_BITS > DEN_W + PRE_W) ? AREA_BITS : DEN_W + PRE_W;
  localparam int STEP_W = $clog2(RATIO_W);

  logic [CMP_W-1:0]   num_ext;
  logic [CMP_W-1:0]   den_sh;
  logic               sat;
  logic               busy_r;
  logic [STEP_W-1:0]  step_r;
  logic [DEN_W-1:0]   den_r;
  logic [DEN_W-1:0]   rem_r;
  logic [RATIO_W-1:0] dq_r;
  logic [DEN_W:0]     trial;
  logic [DEN_W:0]     diff;
  logic               ge;

  assign num_ext = CMP_W'(num);
  assign den_sh  = CMP_W'(den) << PRE_W;
  // quotient would not fit, or empty window
  assign sat     = (den == '0) || (num_ext >= den_sh);

  assign trial = {rem_r, dq_r[RATIO_W-1]};
  assign ge    = (trial >= {1'b0, den_r});
  assign diff  = trial - {1'b0, den_r};

  assign busy = busy_r;
  assign quot = dq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= !sat;
      step_r <= STEP_W'(RATIO_W - 1);
    end else if (busy_r) begin
      if (step_r == '0) begin
        busy_r <= 1'b0;
      end
      step_r <= step_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem_r <= DEN_W'(num_ext >> PRE_W);
      dq_r  <= sat ? {RATIO_W{1'b1}} : {num_ext[PRE_W-1:0], {FRAC_W{1'b0}}};
    end else if (busy_r) begin
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      dq_r  <= {dq_r[RATIO_W-2:0], ge};
    end
  end

endmodule

@@ rtl/wcbc_back.sv @@
`timescale 1ns / 1ps
module wcbc_back import wcbc_pkg::*; #(
  parameter int MAX_DIM   = MAX_DIM_DEF,
  parameter int AREA_BITS = AREA_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  q_entry_t  head,
  input  q_stat_t   q_stat,
  output logic      pop,
  input  logic      out_stall,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int WA_W  = $clog2(MAX_DIM * MAX_DIM + 1);
  localparam int PA_W  = 2 * DIM_W;
  localparam int EP_W  = RA_W + 1 + DIM_W;
  localparam int RA2_W = 2 * FRAC_W + 1;
  localparam int WP_W  = 2 * FRAC_W + WA_W;
  localparam int SUM_W = ((AREA_BITS > PA_W) ? AREA_BITS : PA_W) + 1;
  localparam int TP_W  = RA_W + WA_W;
  localparam int SH_W  = AREA_BITS + FRAC_W;
  localparam int CMP_W = (SH_W > TP_W) ? SH_W : TP_W;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_BEG_A   = 9'b000000010,
    S_BEG_B   = 9'b000000100,
    S_BOX_MUL = 9'b000001000,
    S_BOX_ADD = 9'b000010000,
    S_END_A   = 9'b000100000,
    S_END_B   = 9'b001000000,
    S_DIV     = 9'b010000000,
    S_OUT     = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  q_entry_t             ent_r;
  logic [DIM_W-1:0]     win_l_r, win_t_r, win_r_r, win_b_r;
  logic [WA_W-1:0]      win_area_r;
  logic [AREA_BITS-1:0] area_sum_r;
  logic [CNT_W-1:0]     box_count_r;
  logic [RA2_W-1:0]     ra2_r;
  logic [WA_W-1:0]      wh_r;
  logic [DIM_W-1:0]     dx_r, dy_r;
  logic                 hit_r;
  logic [PA_W-1:0]      aprod_r;
  logic [TP_W-1:0]      thr_r;
  logic                 area_ok_r;
  logic                 out_valid_r;
  out_item_t            out_item_r;

  // clip of the queue head against the window
  logic [CRD_W-1:0] cl, cr, ct, cb;
  logic [CRD_W-1:0] wl, wr, wt, wb;
  logic             hit;

  // window setup
  logic [RA_W-1:0]     ra;
  logic [RA_W-1:0]     lo;
  logic [RA_W:0]       hi;
  logic [DIM_W-1:0]    iw, ih;
  logic [EP_W-1:0]     p_lw, p_hw, p_lh, p_hh;
  logic [2*RA_W-1:0]   p_ra2;
  logic [PA_W-1:0]     p_wh;
  logic [WP_W-1:0]     p_wa;

  logic [SUM_W-1:0] sum_ext;
  logic             sum_sat;
  logic             div_start;
  logic             div_busy;
  logic [RATIO_W-1:0] div_quot;
  logic             load_out;

  assign wl = CRD_W'(win_l_r);
  assign wr = CRD_W'(win_r_r);
  assign wt = CRD_W'(win_t_r);
  assign wb = CRD_W'(win_b_r);
  assign cl = (head.x0 > wl) ? head.x0 : wl;
  assign cr = (head.x1 < wr) ? head.x1 : wr;
  assign ct = (head.y0 > wt) ? head.y0 : wt;
  assign cb = (head.y1 < wb) ? head.y1 : wb;
  assign hit = (cl < cr) && (ct < cb);

  assign ra = (cfg.root_alpha > ONE_Q16) ? ONE_Q16 : cfg.root_alpha;
  assign lo = ONE_Q16 - ra;
  assign hi = {1'b0, ONE_Q16} + {1'b0, ra};
  assign iw = ent_r.x1[DIM_W-1:0];
  assign ih = ent_r.y1[DIM_W-1:0];
  assign p_lw  = EP_W'(lo) * EP_W'(iw);
  assign p_hw  = EP_W'(hi) * EP_W'(iw);
  assign p_lh  = EP_W'(lo) * EP_W'(ih);
  assign p_hh  = EP_W'(hi) * EP_W'(ih);
  assign p_ra2 = (2*RA_W)'(ra) * (2*RA_W)'(ra);
  assign p_wh  = PA_W'(iw) * PA_W'(ih);
  assign p_wa  = WP_W'(ra2_r[2*FRAC_W-1:0]) * WP_W'(wh_r);

  assign sum_ext = SUM_W'(area_sum_r) + SUM_W'(aprod_r);
  assign sum_sat = sum_ext > SUM_W'({AREA_BITS{1'b1}});

  assign div_start = (state_r == S_END_A);
  assign load_out  = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (q_stat.not_empty) begin
          pop = 1'b1;
          case (head.op)
            OP_BEGIN: state_nxt = S_BEG_A;
            OP_BOX:   state_nxt = S_BOX_MUL;
            OP_END:   state_nxt = S_END_A;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_BEG_A:   state_nxt = S_BEG_B;
      S_BEG_B:   state_nxt = S_IDLE;
      S_BOX_MUL: state_nxt = S_BOX_ADD;
      S_BOX_ADD: state_nxt = S_IDLE;
      S_END_A:   state_nxt = S_END_B;
      S_END_B:   state_nxt = S_DIV;
      S_DIV: begin
        if (!div_busy) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      win_l_r     <= '0;
      win_t_r     <= '0;
      win_r_r     <= '0;
      win_b_r     <= '0;
      win_area_r  <= '0;
      area_sum_r  <= '0;
      box_count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_BEG_A) begin
        win_l_r     <= p_lw[FRAC_W+1 +: DIM_W];
        win_r_r     <= p_hw[FRAC_W+1 +: DIM_W];
        win_t_r     <= p_lh[FRAC_W+1 +: DIM_W];
        win_b_r     <= p_hh[FRAC_W+1 +: DIM_W];
        area_sum_r  <= '0;
        box_count_r <= '0;
      end
      if (state_r == S_BEG_B) begin
        // full-size window: ra*ra is exactly 2^32
        win_area_r <= ra2_r[2*FRAC_W] ? wh_r : p_wa[2*FRAC_W +: WA_W];
      end
      if ((state_r == S_BOX_ADD) && hit_r) begin
        if (box_count_r != CNT_MAX) begin
          box_count_r <= box_count_r + 1'b1;
        end
        area_sum_r <= sum_sat ? {AREA_BITS{1'b1}} : sum_ext[AREA_BITS-1:0];
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ent_r <= head;
      hit_r <= hit;
      dx_r  <= DIM_W'(cr - cl);
      dy_r  <= DIM_W'(cb - ct);
    end
    if (state_r == S_BEG_A) begin
      ra2_r <= p_ra2[RA2_W-1:0];
      wh_r  <= p_wh[WA_W-1:0];
    end
    if (state_r == S_BOX_MUL) begin
      aprod_r <= PA_W'(dx_r) * PA_W'(dy_r);
    end
    if (state_r == S_END_A) begin
      thr_r <= TP_W'(cfg.area_threshold) * TP_W'(win_area_r);
    end
    if (state_r == S_END_B) begin
      area_ok_r <= (CMP_W'(area_sum_r) << FRAC_W) > CMP_W'(thr_r);
    end
    if (load_out) begin
      out_item_r.full_screen  <= area_ok_r && (box_count_r > cfg.count_threshold);
      out_item_r.boxes_inside <= box_count_r;
      out_item_r.covered_area <= OUT_AREA_W'(area_sum_r);
      out_item_r.area_ratio   <= div_quot;
    end
  end

  wcbc_div #(
    .AREA_BITS (AREA_BITS),
    .DEN_W     (WA_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (area_sum_r),
    .den   (win_area_r),
    .busy  (div_busy),
    .quot  (div_quot)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ rtl/window_clipped_box_coverage_core.sv @@
`timescale 1ns / 1ps
// Window-clipped box coverage. A begin item sets a window centered in the image
// (sides scaled by root_alpha, Q1.16), box items are clipped to it and their
// clipped areas summed, and an end item returns count, area, area ratio (Q8.16)
// and the full-screen flag. Items enter a 2-entry queue and are executed by a
// sequencer: begin items pass BEG_A and BEG_B, box items BOX_MUL and BOX_ADD,
// and an end item END_A, END_B, the bit-serial ratio divider (skipped when the
// ratio saturates or the window is empty) and OUT, plus a wait when the result
// register is stalled. Command 3 is accepted and dropped. Write configuration
// only while the block is idle; root_alpha applies from the next begin item.
module window_clipped_box_coverage_core import wcbc_pkg::*; #(
  parameter int MAX_DIM   = MAX_DIM_DEF,
  parameter int AREA_BITS = AREA_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  in_item_t              in_item,
  output logic                  in_stall,
  output logic                  out_valid,
  output out_item_t             out_item,
  input  logic                  out_stall,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  cfg_t     cfg_r;
  logic     cfg_wr;
  logic [1:0] reg_idx;
  logic     push;
  logic     pop;
  q_entry_t ent_in;
  q_entry_t head;
  q_stat_t  q_stat;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.root_alpha      <= ROOT_ALPHA_RST;
      cfg_r.area_threshold  <= AREA_THR_RST;
      cfg_r.count_threshold <= COUNT_THR_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_ROOT_ALPHA: cfg_r.root_alpha      <= cfg_pwdata[RA_W-1:0];
        REG_AREA_THR:   cfg_r.area_threshold  <= cfg_pwdata[RA_W-1:0];
        REG_COUNT_THR:  cfg_r.count_threshold <= cfg_pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ROOT_ALPHA: cfg_prdata = CFG_DATA_W'(cfg_r.root_alpha);
      REG_AREA_THR:   cfg_prdata = CFG_DATA_W'(cfg_r.area_threshold);
      REG_COUNT_THR:  cfg_prdata = CFG_DATA_W'(cfg_r.count_threshold);
      default:        cfg_prdata = '0;
    endcase
  end

  wcbc_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .in_valid (in_valid),
    .in_item  (in_item),
    .in_stall (in_stall),
    .q_stat   (q_stat),
    .push     (push),
    .ent      (ent_in)
  );

  wcbc_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .ent_in (ent_in),
    .pop    (pop),
    .head   (head),
    .q_stat (q_stat)
  );

  wcbc_back #(
    .MAX_DIM   (MAX_DIM),
    .AREA_BITS (AREA_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

@@ rtl/wcbc_checker.sv @@
`timescale 1ns / 1ps
module wcbc_checker import wcbc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input out_item_t out_item,
  input logic      out_stall
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed or dropped while stalled");

  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_rst_in: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

  // area grows only with a counted hit box (the count saturates), and both clear together
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.boxes_inside == '0) |->
      (out_item.covered_area == '0) && !out_item.full_screen)
    else $error("area or flag without any counted box");

endmodule

bind window_clipped_box_coverage_core wcbc_checker u_wcbc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_item  (out_item),
  .out_stall (out_stall)
);

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import wcbc_pkg::*;

  class box_coverage_tracker;

    logic [RA_W-1:0]       root_alpha;
    logic [RA_W-1:0]       area_thr;
    logic [CNT_W-1:0]      count_thr;
    logic [12:0]           win_l, win_t, win_r, win_b;
    logic [24:0]           win_area;
    logic [39:0]           area_sum;
    logic [CNT_W-1:0]      box_cnt;
    out_item_t             pending_reports[$];
    int                    errors;

    function new();
      root_alpha = ROOT_ALPHA_RST;
      area_thr   = AREA_THR_RST;
      count_thr  = COUNT_THR_RST;
      win_l = '0; win_t = '0; win_r = '0; win_b = '0;
      win_area = '0;
      area_sum = '0;
      box_cnt  = '0;
      errors   = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_ROOT_ALPHA: root_alpha = val[RA_W-1:0];
        REG_AREA_THR:   area_thr   = val[RA_W-1:0];
        REG_COUNT_THR:  count_thr  = val[CNT_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_item(in_item_t it);
      bit [63:0] w, h, ra, lo, hi;
      bit [63:0] bl, bt, br, bb, l, t, r, b, a;
      bit [63:0] scaled, ratio;
      bit [63:0] area_max;
      out_item_t rpt;
      area_max = (64'd1 << 40) - 1;
      case (it.command)
        CMD_BEGIN: begin
          w  = (it.image_width  > MAX_DIM_DEF) ? 64'(MAX_DIM_DEF) : 64'(it.image_width);
          h  = (it.image_height > MAX_DIM_DEF) ? 64'(MAX_DIM_DEF) : 64'(it.image_height);
          ra = (root_alpha > ONE_Q16) ? 64'(ONE_Q16) : 64'(root_alpha);
          lo = 64'd65536 - ra;
          hi = 64'd65536 + ra;
          win_l = 13'((lo * w) >> 17);
          win_r = 13'((hi * w) >> 17);
          win_t = 13'((lo * h) >> 17);
          win_b = 13'((hi * h) >> 17);
          win_area = 25'((ra * ra * w * h) >> 32);
          area_sum = '0;
          box_cnt  = '0;
        end
        CMD_BOX: begin
          bl = 64'(it.box_left);
          bt = 64'(it.box_top);
          br = bl + 64'(it.box_width);
          bb = bt + 64'(it.box_height);
          l = (bl > 64'(win_l)) ? bl : 64'(win_l);
          t = (bt > 64'(win_t)) ? bt : 64'(win_t);
          r = (br < 64'(win_r)) ? br : 64'(win_r);
          b = (bb < 64'(win_b)) ? bb : 64'(win_b);
          if (l < r && t < b) begin
            a = (r - l) * (b - t);
            if (box_cnt != CNT_MAX) box_cnt++;
            if (a > area_max - 64'(area_sum)) area_sum = area_max[39:0];
            else area_sum = 40'(64'(area_sum) + a);
          end
        end
        CMD_END: begin
          scaled = 64'(area_sum) << 16;
          if (win_area == 0) ratio = 64'hFF_FFFF;
          else begin
            ratio = scaled / 64'(win_area);
            if (ratio > 64'hFF_FFFF) ratio = 64'hFF_FFFF;
          end
          rpt.full_screen  = (scaled > 64'(area_thr) * 64'(win_area)) &&
                             (box_cnt > count_thr);
          rpt.boxes_inside = box_cnt;
          rpt.covered_area = area_sum;
          rpt.area_ratio   = ratio[RATIO_W-1:0];
          pending_reports.push_back(rpt);
        end
        default: ;  // unused command is dropped
      endcase
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_report(out_item_t got);
      out_item_t want;
      if (pending_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected report: expected none actual %0h", $time, got);
      end else begin
        want = pending_reports.pop_front();
        compare_field("full_screen",  64'(want.full_screen),  64'(got.full_screen));
        compare_field("boxes_inside", 64'(want.boxes_inside), 64'(got.boxes_inside));
        compare_field("covered_area", 64'(want.covered_area), 64'(got.covered_area));
        compare_field("area_ratio",   64'(want.area_ratio),   64'(got.area_ratio));
      end
    endfunction
  endclass

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam logic [1:0] REG_SPARE   = 2'd3;
  localparam int         DRAIN_CYCLES = 64;
  localparam int         STALL_LIMIT  = 4000;
  localparam int         PHASES       = 8;
  localparam int         PHASE_ITEMS  = 48;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  in_item_t              in_item = '0;
  logic                  in_stall;
  logic                  out_valid;
  out_item_t             out_item;
  logic                  out_stall = 1'b0;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  box_coverage_tracker   tracker = new();
  int                    send_idle_pct = 0;
  int                    stall_pct = 0;
  int                    items_sent = 0;
  int                    idle_cycles = 0;
  int                    cur_w = 0;
  int                    cur_h = 0;

  int ra_set   [PHASES] = '{65536, 0, 32768, 'h1FFFF, 46341, 1, 16, 53000};
  int athr_set [PHASES] = '{32768, 0, 'h1FFFF, 65536, 16384, 0, 65536, 45000};
  int cthr_set [PHASES] = '{10, 0, 65535, 3, 5, 0, 1, 8};

  window_clipped_box_coverage_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_item     (in_item),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_item    (out_item),
    .out_stall   (out_stall),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  // results first: a result never belongs to an item taken at the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) tracker.check_report(out_item);
      if (in_valid && !in_stall) tracker.note_item(in_item);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_psel || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress, %0d reports outstanding", $time,
               tracker.pending_reports.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic in_item_t make_item(logic [1:0] cmd, int iw, int ih,
                                         int bl, int bt, int bw, int bh);
    in_item_t it;
    it.command      = cmd;
    it.image_width  = 13'(iw);
    it.image_height = 13'(ih);
    it.box_left     = 12'(bl);
    it.box_top      = 12'(bt);
    it.box_width    = 13'(bw);
    it.box_height   = 13'(bh);
    return it;
  endfunction

  // unused fields carry random bits too
  function automatic in_item_t random_item(logic [1:0] cmd);
    return make_item(cmd, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  function automatic int random_dim();
    int r;
    r = $urandom_range(99);
    if (r < 10) return $urandom_range(0, 16);
    if (r < 20) return MAX_DIM_DEF;
    if (r < 30) return $urandom_range(MAX_DIM_DEF + 1, 8191);
    return $urandom_range(17, MAX_DIM_DEF - 1);
  endfunction

  function automatic int random_edge(int dim);
    int top_lim;
    top_lim = (dim > 4095) ? 4095 : dim;
    if ($urandom_range(99) < 85) return $urandom_range(0, top_lim);
    return $urandom_range(0, 4095);
  endfunction

  function automatic int random_span(int dim);
    int r;
    r = $urandom_range(99);
    if (r < 40) return $urandom_range(0, 64);
    if (r < 80) return $urandom_range(0, (dim < 1) ? 1 : dim);
    if (r < 92) return $urandom_range(0, 8191);
    return 0;
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    gap = 0;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    if (it.command != CMD_UNUSED) items_sent++;
  endtask

  task automatic send_begin();
    in_item_t it;
    it = random_item(CMD_BEGIN);
    it.image_width  = 13'(random_dim());
    it.image_height = 13'(random_dim());
    cur_w = (it.image_width  > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(it.image_width);
    cur_h = (it.image_height > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(it.image_height);
    send_item(it);
  endtask

  task automatic send_box();
    in_item_t it;
    it = random_item(CMD_BOX);
    it.box_left   = 12'(random_edge(cur_w));
    it.box_top    = 12'(random_edge(cur_h));
    it.box_width  = 13'(random_span(cur_w));
    it.box_height = 13'(random_span(cur_h));
    send_item(it);
  endtask

  task automatic run_sequence();
    int kind;
    int n;
    kind = $urandom_range(99);
    n = $urandom_range(0, 24);
    if (kind < 8) begin
      send_item(random_item(CMD_UNUSED));
    end else if (kind < 14) begin
      // keep adding to the previous image without a new begin
      repeat (n) send_box();
      send_item(random_item(CMD_END));
    end else begin
      send_begin();
      repeat (n) begin
        if ($urandom_range(99) < 4) send_item(random_item(CMD_UNUSED));
        send_box();
      end
      send_item(random_item(CMD_END));
      if ($urandom_range(99) < 15) send_item(random_item(CMD_END));
    end
  endtask

  // 1x1 window with area 1: enough boxes push the ratio past Q8.16 range
  task automatic saturate_ratio();
    send_item(make_item(CMD_BEGIN, 4096, 4096, 0, 0, 0, 0));
    repeat (260) send_item(make_item(CMD_BOX, 0, 0, 0, 0, 4096, 4096));
    send_item(make_item(CMD_END, 0, 0, 0, 0, 0, 0));
  endtask

  // one edge first so the last accepted item is already noted
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    tracker.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic directed_items();
    // boxes ahead of any begin clip against the all-zero window
    send_item(make_item(CMD_BOX, 0, 0, 0, 0, 4096, 4096));
    send_item(make_item(CMD_END, 0, 0, 0, 0, 0, 0));
    send_item(make_item(CMD_UNUSED, 0, 0, 0, 0, 0, 0));
    send_item(make_item(CMD_BEGIN, 4096, 4096, 0, 0, 0, 0));
    send_item(make_item(CMD_BOX, 0, 0, 0, 0, 4096, 4096));
    send_item(make_item(CMD_BOX, 0, 0, 4095, 4095, 8191, 8191));
    send_item(make_item(CMD_BOX, 0, 0, 100, 100, 0, 50));
    send_item(make_item(CMD_BOX, 0, 0, 4095, 0, 1, 0));
    send_item(make_item(CMD_END, 0, 0, 0, 0, 0, 0));
    send_item(make_item(CMD_END, 8191, 8191, 4095, 4095, 8191, 8191));
    // oversized image is capped
    send_item(make_item(CMD_BEGIN, 8191, 8191, 0, 0, 0, 0));
    send_item(make_item(CMD_BOX, 0, 0, 4095, 4095, 8191, 8191));
    send_item(make_item(CMD_END, 0, 0, 0, 0, 0, 0));
    // empty window
    send_item(make_item(CMD_BEGIN, 0, 0, 0, 0, 0, 0));
    send_item(make_item(CMD_BOX, 0, 0, 0, 0, 5, 5));
    send_item(make_item(CMD_END, 0, 0, 0, 0, 0, 0));
    send_item(make_item(CMD_BEGIN, 1, 1, 0, 0, 0, 0));
    send_item(make_item(CMD_BOX, 0, 0, 0, 0, 1, 1));
    send_item(make_item(CMD_END, 0, 0, 0, 0, 0, 0));
    send_item(make_item(CMD_UNUSED, 8191, 8191, 4095, 4095, 8191, 8191));
    send_item(make_item(CMD_BEGIN, 4096, 1, 0, 0, 0, 0));
    send_item(make_item(CMD_BOX, 0, 0, 0, 0, 4096, 1));
    send_item(make_item(CMD_END, 0, 0, 0, 0, 0, 0));
  endtask

  initial begin
    int mark;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_items();
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      reg_write(REG_ROOT_ALPHA, ra_set[ph]);
      reg_write(REG_AREA_THR, athr_set[ph]);
      reg_write(REG_COUNT_THR, cthr_set[ph]);
      if (ph == 2) reg_write(REG_SPARE, $urandom);
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 76; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 76; end
        default: begin send_idle_pct = 18; stall_pct = 18; end
      endcase
      if (ra_set[ph] == 16) saturate_ratio();
      mark = items_sent;
      while (items_sent - mark < PHASE_ITEMS) run_sequence();
    end
    drain();
    if (tracker.pending_reports.size() != 0)
      $display("%0t: missing report: expected %0d more actual 0", $time,
               tracker.pending_reports.size());
    if (tracker.errors == 0 && tracker.pending_reports.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/wcbc_pkg.sv
rtl/wcbc_front.sv
rtl/wcbc_queue.sv
rtl/wcbc_div.sv
rtl/wcbc_back.sv
rtl/window_clipped_box_coverage_core.sv
rtl/wcbc_checker.sv
bench/testbench.sv
